// ===== rtl/assert_macros.svh =====
// ----------------------------------------------------------------------------
// assert_macros.svh
// shared concurrent assertion macros, compiled out with ASSERT_OFF
// ----------------------------------------------------------------------------
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

`ifndef ASSERT_OFF

// property must hold at every clock edge outside reset
`define ASSERT_ALWAYS(lbl, clk, rst_n, prop) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (prop)) \
        else $error("assertion failed");

// antecedent implies consequent in the same cycle
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");

// antecedent implies consequent in the next cycle
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");

`else

`define ASSERT_ALWAYS(lbl, clk, rst_n, prop)
`define ASSERT_IMPLY(lbl, clk, rst_n, ante, cons)
`define ASSERT_NEXT(lbl, clk, rst_n, ante, cons)

`endif

`endif

// ===== rtl/sqd_pkg.sv =====
// ----------------------------------------------------------------------------
// sqd_pkg
// shared types, codes and the alphabet lookup of the base64 quad decoder
// ----------------------------------------------------------------------------
package sqd_pkg;

    localparam logic [7:0]  PAD_CHAR       = 8'h3D;
    localparam logic [15:0] MAX_BYTES_RST  = 16'h6000;
    localparam int          CNT_W          = 17;

    // error codes carried on the result channel
    localparam logic [2:0] ERR_NONE    = 3'd0;
    localparam logic [2:0] ERR_PADDING = 3'd1;
    localparam logic [2:0] ERR_CHAR    = 3'd2;
    localparam logic [2:0] ERR_PADBITS = 3'd3;
    localparam logic [2:0] ERR_LENGTH  = 3'd4;

    // one result byte with its flags
    typedef struct packed {
        logic [7:0] data;
        logic       last;
        logic       failed;
        logic [2:0] code;
    } t_result;

    // decoder outcome for one quad
    typedef struct packed {
        logic [1:0]       num_res;
        t_result [2:0]    res;
        logic [CNT_W-1:0] next_count;
        logic             next_latched;
    } t_dec;

    // six-bit value of a character, bit 6 set when outside the alphabet
    function automatic logic [6:0] sextet(input logic [7:0] ch);
        logic [6:0] v;
        case (ch) inside
            [8'h41:8'h5A]: v = {1'b0, 6'(ch - 8'h41)};
            [8'h61:8'h7A]: v = {1'b0, 6'(ch - 8'h47)};
            [8'h30:8'h39]: v = {1'b0, 6'(ch + 8'd4)};
            8'h2B:         v = 7'd62;
            8'h2F:         v = 7'd63;
            default:       v = 7'h40;
        endcase
        return v;
    endfunction

endpackage

// ===== rtl/strict_base64_quad_decoder_unit.sv =====
// ----------------------------------------------------------------------------
// strict_base64_quad_decoder_unit
// strict canonical base64 decoder, one quad in, zero to three results out
// ----------------------------------------------------------------------------
// Usage:
//   input channel (i_in_valid / o_in_ready) carries one quad of four ASCII
//   characters and a final-quad flag per request. output channel
//   (o_out_valid / i_out_ready) carries one decoded byte or one error result
//   per request. the config channel (i_cfg_valid / o_cfg_ready) writes the
//   maximum decoded string length and is always ready; write it only while
//   the block is idle.
//   a quad is held in the input register, then decoded into the result
//   buffer once the buffer is free; the buffer head drives the output
//   port. the one-byte output port carries one result per transfer, so a
//   full quad gives three transfers and a swallowed quad none. a new quad
//   is taken while the previous quad's bytes drain, and decode happens as
//   the buffer empties.
//   reset clears the string state, empties all stages and restores the
//   maximum to 24576. when the receiver stalls, the buffer and input
//   register fill and o_in_ready drops; nothing is lost.
// ----------------------------------------------------------------------------
`include "assert_macros.svh"

module strict_base64_quad_decoder_unit
    import sqd_pkg::*;
(
    input  logic        i_clk,
    input  logic        i_rst_n,
    input  logic        i_in_valid,
    output logic        o_in_ready,
    input  logic [7:0]  i_char_first,
    input  logic [7:0]  i_char_second,
    input  logic [7:0]  i_char_third,
    input  logic [7:0]  i_char_fourth,
    input  logic        i_final_quad,
    input  logic        i_cfg_valid,
    output logic        o_cfg_ready,
    input  logic [15:0] i_cfg_max_output_bytes,
    output logic        o_out_valid,
    input  logic        i_out_ready,
    output logic [7:0]  o_data_byte,
    output logic        o_last_of_run,
    output logic        o_failed,
    output logic [2:0]  o_error_code
);

    logic             r_in_valid, n_in_valid;
    logic [7:0]       r_c0, r_c1, r_c2, r_c3;
    logic             r_fin;
    logic [15:0]      r_max, n_max;
    logic [CNT_W-1:0] r_count, n_count;
    logic             r_latched, n_latched;
    logic [1:0]       r_rem, n_rem;
    t_result [2:0]    r_buf, n_buf;
    t_dec             dec;
    logic             pop, buf_free, move;
    logic             err_head_ok;

    // handshake control
    assign pop         = (r_rem != 2'd0) && i_out_ready;
    assign buf_free    = (r_rem == 2'd0) || (pop && (r_rem == 2'd1));
    assign move        = r_in_valid && buf_free;
    assign o_in_ready  = !r_in_valid || move;
    assign o_cfg_ready = 1'b1;

    // decode of the registered quad
    sqd_decode u_decode (
        .i_char_first  (r_c0),
        .i_char_second (r_c1),
        .i_char_third  (r_c2),
        .i_char_fourth (r_c3),
        .i_final_quad  (r_fin),
        .i_count       (r_count),
        .i_latched     (r_latched),
        .i_max_bytes   (r_max),
        .o_dec         (dec)
    );

    // next-state logic for stages, string state and config
    always_comb begin
        n_in_valid = r_in_valid;
        if (move) begin
            n_in_valid = 1'b0;
        end
        if (i_in_valid && o_in_ready) begin
            n_in_valid = 1'b1;
        end
        n_count   = move ? dec.next_count : r_count;
        n_latched = move ? dec.next_latched : r_latched;
        n_max     = (i_cfg_valid && o_cfg_ready) ? i_cfg_max_output_bytes : r_max;
        n_rem     = r_rem;
        n_buf     = r_buf;
        if (move) begin
            n_rem = dec.num_res;
            n_buf = dec.res;
        end else if (pop) begin
            n_rem    = r_rem - 2'd1;
            n_buf[0] = r_buf[1];
            n_buf[1] = r_buf[2];
        end
    end

    // control registers
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_in_valid <= 1'b0;
            r_count    <= '0;
            r_latched  <= 1'b0;
            r_max      <= MAX_BYTES_RST;
            r_rem      <= 2'd0;
        end else begin
            r_in_valid <= n_in_valid;
            r_count    <= n_count;
            r_latched  <= n_latched;
            r_max      <= n_max;
            r_rem      <= n_rem;
        end
    end

    // payload registers
    always_ff @(posedge i_clk) begin
        if (i_in_valid && o_in_ready) begin
            r_c0  <= i_char_first;
            r_c1  <= i_char_second;
            r_c2  <= i_char_third;
            r_c3  <= i_char_fourth;
            r_fin <= i_final_quad;
        end
        r_buf <= n_buf;
    end

    // result port from the head of the buffer
    assign o_out_valid   = (r_rem != 2'd0);
    assign o_data_byte   = r_buf[0].data;
    assign o_last_of_run = r_buf[0].last;
    assign o_failed      = r_buf[0].failed;
    assign o_error_code  = r_buf[0].code;

    // checks
    assign err_head_ok = o_last_of_run && (o_data_byte == 8'd0) && (r_rem == 2'd1);

    `ASSERT_IMPLY(a_err_shape, i_clk, i_rst_n, o_out_valid && o_failed, err_head_ok)
    `ASSERT_IMPLY(a_ok_code, i_clk, i_rst_n, o_out_valid && !o_failed, o_error_code == ERR_NONE)
    `ASSERT_NEXT(a_final_clears, i_clk, i_rst_n, move && r_fin, (r_count == '0) && !r_latched)
    `ASSERT_IMPLY(a_no_overwrite, i_clk, i_rst_n, move, (r_rem == 2'd0) || (pop && (r_rem == 2'd1)))

endmodule

// ===== rtl/sqd_decode.sv =====
// ----------------------------------------------------------------------------
// sqd_decode
// validates one quad against the string state and forms its result bytes
// ----------------------------------------------------------------------------
module sqd_decode
    import sqd_pkg::*;
(
    input  logic [7:0]       i_char_first,
    input  logic [7:0]       i_char_second,
    input  logic [7:0]       i_char_third,
    input  logic [7:0]       i_char_fourth,
    input  logic             i_final_quad,
    input  logic [CNT_W-1:0] i_count,
    input  logic             i_latched,
    input  logic [15:0]      i_max_bytes,
    output t_dec             o_dec
);

    logic [6:0]       s_a, s_b, s_c, s_d;
    logic [5:0]       v_c, v_d;
    logic             p2, p3;
    logic [1:0]       n_bytes;
    logic [CNT_W:0]   sum;
    logic [2:0]       code;
    logic [23:0]      bits;

    // character lookup and padding detection
    always_comb begin
        p2  = (i_char_third == PAD_CHAR);
        p3  = (i_char_fourth == PAD_CHAR);
        s_a = sextet(i_char_first);
        s_b = sextet(i_char_second);
        s_c = p2 ? 7'd0 : sextet(i_char_third);
        s_d = p3 ? 7'd0 : sextet(i_char_fourth);
        v_c = s_c[5:0];
        v_d = s_d[5:0];
        n_bytes = p2 ? 2'd1 : (p3 ? 2'd2 : 2'd3);
        sum  = {1'b0, i_count} + {{(CNT_W - 1){1'b0}}, n_bytes};
        bits = {s_a[5:0], s_b[5:0], v_c, v_d};
    end

    // checks in priority order: padding, characters, pad bits, length
    always_comb begin
        if ((!i_final_quad && (p2 || p3)) || (p2 && !p3)) begin
            code = ERR_PADDING;
        end else if (s_a[6] || s_b[6] || s_c[6] || s_d[6]) begin
            code = ERR_CHAR;
        end else if ((p2 && (s_b[3:0] != 4'd0)) || (p3 && !p2 && (v_c[1:0] != 2'd0))) begin
            code = ERR_PADBITS;
        end else if (sum > {2'b00, i_max_bytes}) begin
            code = ERR_LENGTH;
        end else begin
            code = ERR_NONE;
        end
    end

    // results and next string state
    always_comb begin
        o_dec = '0;
        o_dec.next_count   = i_count;
        o_dec.next_latched = i_latched;
        if (i_latched) begin
            // swallowing a failed string until its final quad
            if (i_final_quad) begin
                o_dec.next_count   = '0;
                o_dec.next_latched = 1'b0;
            end
        end else if (code != ERR_NONE) begin
            o_dec.num_res       = 2'd1;
            o_dec.res[0].data   = 8'd0;
            o_dec.res[0].last   = 1'b1;
            o_dec.res[0].failed = 1'b1;
            o_dec.res[0].code   = code;
            if (i_final_quad) begin
                o_dec.next_count   = '0;
                o_dec.next_latched = 1'b0;
            end else begin
                o_dec.next_latched = 1'b1;
            end
        end else begin
            o_dec.num_res     = n_bytes;
            o_dec.res[0].data = bits[23:16];
            o_dec.res[0].last = i_final_quad && (n_bytes == 2'd1);
            o_dec.res[1].data = bits[15:8];
            o_dec.res[1].last = i_final_quad && (n_bytes == 2'd2);
            o_dec.res[2].data = bits[7:0];
            o_dec.res[2].last = i_final_quad;
            o_dec.next_count  = i_final_quad ? '0 : sum[CNT_W-1:0];
        end
    end

endmodule
